// File: hdl/modbus_rtu_slave_engine_core_defines.svh
// Assertion macros for the Modbus RTU slave engine.
// Used by the top level only; define NO_ASSERTIONS to leave the checks out.
`ifndef MODBUS_RTU_SLAVE_ENGINE_CORE_DEFINES_SVH
`define MODBUS_RTU_SLAVE_ENGINE_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define MRS_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
`define MRS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define MRS_ASSERT_IMPL(label, ante, cons)
`define MRS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: hdl/mrs_pkg.sv
// Shared types and constants of the Modbus RTU slave engine.
// No dependencies.
package mrs_pkg;
	localparam logic [7:0] FC_READ_HOLD  = 8'h03;
	localparam logic [7:0] FC_READ_INPUT = 8'h04;
	localparam logic [7:0] FC_WRITE_ONE  = 8'h06;
	localparam logic [7:0] EXC_FLAG      = 8'h80;
	localparam logic [7:0] EXC_FUNC      = 8'h01;
	localparam logic [7:0] EXC_ADDR      = 8'h02;
	localparam logic [7:0] EXC_VALUE     = 8'h03;
	localparam logic [3:0] INPUT_REG_COUNT = 4'd11;

	localparam logic [2:0] REG_SLAVE = 3'd0;
	localparam logic [2:0] REG_BCAST = 3'd1;
	localparam logic [2:0] REG_BOARD = 3'd2;
	localparam logic [2:0] REG_DATE  = 3'd3;
	localparam logic [2:0] REG_TIME  = 3'd4;
	localparam logic [2:0] REG_VER   = 3'd5;
	localparam logic [2:0] REG_MASK  = 3'd6;

	// Classified frame handed from front to back.
	typedef struct packed {
		logic        reply;      // answer with bytes
		logic        is_exc;
		logic [7:0]  exc_num;
		logic        is_echo;    // write echo
		logic        is_read;
		logic        rd_input;   // 04 rather than 03
		logic [3:0]  start;
		logic [3:0]  cnt;
		logic [7:0]  code;
		logic [47:0] head;
		logic [15:0] up_ma;
		logic [15:0] lo_ma;
		logic [15:0] lux_f;
		logic [15:0] lux_b;
		logic        mchg;
		logic        bchg;
	} job_t;

	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++)
			c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
		return c;
	endfunction
endpackage

// File: hdl/mrs_front.sv
// Receive front: gathers frame bytes, running CRC, classifies at frame end.
// Depends on mrs_pkg.
module mrs_front import mrs_pkg::*; #(
	parameter int RX_FRAME_MAX = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        cmd,
	input  logic [7:0]  rx_byte,
	input  logic [15:0] upper_current_ma,
	input  logic [15:0] lower_current_ma,
	input  logic [15:0] front_lux,
	input  logic [15:0] rear_lux,
	input  logic [7:0]  slave_address,
	input  logic [7:0]  broadcast_address,
	input  logic [15:0] mode_valid_mask,
	input  logic        q_full,
	output logic        push,
	output job_t        job
);
	localparam int CW = $clog2(RX_FRAME_MAX + 2);
	logic [7:0]    head_q [6];
	logic [CW-1:0] cnt_q;
	logic [15:0]   crc_q, tail_q;
	logic [15:0]   a, v, rx_crc;
	logic [7:0]    code;
	logic          ok;

	assign in_ready = !q_full;
	wire acc = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			crc_q <= 16'hFFFF;
			tail_q <= '0;
		end else if (acc) begin
			if (cmd) begin
				cnt_q <= '0;
				crc_q <= 16'hFFFF;
				tail_q <= '0;
			end else begin
				if (cnt_q >= CW'(2)) crc_q <= crc_feed(crc_q, tail_q[15:8]);
				tail_q <= {tail_q[7:0], rx_byte};
				if (cnt_q <= CW'(RX_FRAME_MAX)) cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && !cmd && cnt_q < CW'(6)) head_q[cnt_q[2:0]] <= rx_byte;
	end

	always_comb begin
		a = {head_q[2], head_q[3]};
		v = {head_q[4], head_q[5]};
		code = head_q[1];
		rx_crc = {tail_q[7:0], tail_q[15:8]};
		ok = cnt_q >= CW'(4) && cnt_q <= CW'(RX_FRAME_MAX)
			&& (head_q[0] == slave_address || head_q[0] == broadcast_address)
			&& crc_q == rx_crc;
		job = '0;
		job.code = code;
		job.head = {head_q[0], head_q[1], head_q[2], head_q[3], head_q[4], head_q[5]};
		job.up_ma = upper_current_ma;
		job.lo_ma = lower_current_ma;
		job.lux_f = front_lux;
		job.lux_b = rear_lux;
		job.start = a[3:0];
		job.cnt = v[3:0];
		if (ok) begin
			job.reply = head_q[0] == slave_address;
			job.is_exc = 1'b1;
			priority if (cnt_q != CW'(8) || (code != FC_READ_HOLD && code != FC_READ_INPUT
				&& code != FC_WRITE_ONE)) job.exc_num = EXC_FUNC;
			else if (code == FC_READ_HOLD) begin
				if (a > 16'd1) job.exc_num = EXC_ADDR;
				else if (v == 16'd0 || {1'b0, v} + {1'b0, a} > 17'd2) job.exc_num = EXC_VALUE;
				else begin job.is_exc = 1'b0; job.is_read = 1'b1; end
			end else if (code == FC_READ_INPUT) begin
				if (a >= 16'(INPUT_REG_COUNT)) job.exc_num = EXC_ADDR;
				else if (v == 16'd0 || {1'b0, v} + {1'b0, a} > 17'(INPUT_REG_COUNT))
					job.exc_num = EXC_VALUE;
				else begin job.is_exc = 1'b0; job.is_read = 1'b1; job.rd_input = 1'b1; end
			end else begin
				if (a == 16'd0) begin
					if (v < 16'd16 && mode_valid_mask[v[3:0]]) begin
						job.is_exc = 1'b0; job.is_echo = 1'b1; job.mchg = 1'b1;
					end else job.exc_num = EXC_VALUE;
				end else if (a == 16'd1) begin
					if (v <= 16'd255) begin
						job.is_exc = 1'b0; job.is_echo = 1'b1; job.bchg = 1'b1;
					end else job.exc_num = EXC_VALUE;
				end else job.exc_num = EXC_ADDR;
			end
		end
	end

	assign push = acc && cmd;
endmodule

// File: hdl/mrs_fifo.sv
// Two-entry queue of classified frames between front and back.
// Depends on mrs_pkg.
module mrs_fifo import mrs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t wdata,
	output logic full,
	input  logic pop,
	output logic nempty,
	output job_t rdata
);
	job_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full = cnt_q == 2'd2;
	assign nempty = cnt_q != 2'd0;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

// File: hdl/mrs_back.sv
// Reply back end: executes a classified frame and streams reply bytes with CRC.
// Depends on mrs_pkg.
module mrs_back import mrs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        job_valid,
	input  job_t        job,
	output logic        job_pop,
	input  logic [7:0]  slave_address,
	input  logic [15:0] board_number,
	input  logic [15:0] build_date_word,
	input  logic [15:0] build_time_word,
	input  logic [15:0] version_word,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        has_byte,
	output logic [7:0]  tx_byte,
	output logic        last,
	output logic        mode_changed,
	output logic        brightness_changed,
	output logic [15:0] mode_value,
	output logic [7:0]  brightness_value
);
	logic [15:0] mode_q;
	logic [7:0]  bright_q;
	logic        busy_q;
	logic [4:0]  idx_q, n_body;
	logic [15:0] crc_q;
	logic [7:0]  body_byte, cur;
	logic [15:0] reg_w;
	logic [3:0]  ri;
	logic        emit, out_free;

	assign n_body = job.is_exc ? 5'd3 : job.is_echo ? 5'd6 : 5'd3 + {job.cnt, 1'b0};
	assign ri = job.start + 4'((idx_q - 5'd3) >> 1);

	always_comb begin
		reg_w = '0;
		if (!job.rd_input) reg_w = ri[0] ? {8'h00, bright_q} : mode_q;
		else unique case (ri)
			4'd0: reg_w = board_number;
			4'd1: reg_w = build_date_word;
			4'd2: reg_w = build_time_word;
			4'd3: reg_w = version_word;
			4'd4: reg_w = mode_q;
			4'd5: reg_w = job.up_ma;
			4'd7: reg_w = job.lo_ma;
			4'd9: reg_w = job.lux_f;
			4'd10: reg_w = job.lux_b;
			default: reg_w = '0;
		endcase
		body_byte = 8'h00;
		if (job.is_echo) body_byte = job.head[8'(47 - 8 * idx_q) -: 8];
		else if (idx_q == 5'd0) body_byte = slave_address;
		else if (idx_q == 5'd1) body_byte = job.is_exc ? (job.code | EXC_FLAG) : job.code;
		else if (idx_q == 5'd2) body_byte = job.is_exc ? job.exc_num : {3'b000, job.cnt, 1'b0};
		else body_byte = idx_q[0] ? reg_w[15:8] : reg_w[7:0];
		if (idx_q < n_body) cur = body_byte;
		else if (idx_q == n_body) cur = crc_q[7:0];
		else cur = crc_q[15:8];
	end

	assign out_free = !out_valid || out_ready;
	assign emit = job_valid && out_free && (busy_q || !job.reply);
	wire fin = emit && (!job.reply || idx_q == n_body + 5'd1);
	assign job_pop = fin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= '0; bright_q <= '0; busy_q <= 1'b0; idx_q <= '0;
			crc_q <= 16'hFFFF; out_valid <= 1'b0;
		end else begin
			if (emit) out_valid <= 1'b1;
			else if (out_valid && out_ready) out_valid <= 1'b0;
			if (fin) busy_q <= 1'b0;
			else if (job_valid && !busy_q && job.reply && out_free) busy_q <= 1'b1;
			if (emit) begin
				if (fin) begin
					if (job.mchg) mode_q <= {12'h000, job.head[3:0]};
					if (job.bchg) bright_q <= job.head[7:0];
					idx_q <= '0; crc_q <= 16'hFFFF;
				end else begin
					if (idx_q < n_body) crc_q <= crc_feed(crc_q, cur);
					idx_q <= idx_q + 1'b1;
				end
			end
		end
	end

	// Every result of a frame carries the register values after that frame.
	always_ff @(posedge clk) begin
		if (emit) begin
			has_byte <= job.reply;
			tx_byte <= job.reply ? cur : 8'h00;
			last <= fin;
			mode_changed <= fin && job.mchg;
			brightness_changed <= fin && job.bchg;
			mode_value <= job.mchg ? {12'h000, job.head[3:0]} : mode_q;
			brightness_value <= job.bchg ? job.head[7:0] : bright_q;
		end
	end
endmodule

// File: hdl/modbus_rtu_slave_engine_core.sv
// Modbus RTU slave engine, top level. Depends on mrs_pkg, front, queue, back.
// A byte transaction is absorbed when accepted; a frame end's first result is registered from
// the queue directly if status only, after a setup step (busy) if answered. Throughput: one
// result per cycle while the output is ready, setup aside; a frame end holds the back end for
// its status result or for setup plus 5 to 27 reply bytes; input stalls only while the queue
// holds two frame ends. Reset is asynchronous, active low, all control cleared.
`include "modbus_rtu_slave_engine_core_defines.svh"
module modbus_rtu_slave_engine_core import mrs_pkg::*; #(
	parameter int RX_FRAME_MAX = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        cmd,
	input  logic [7:0]  rx_byte,
	input  logic [15:0] upper_current_ma,
	input  logic [15:0] lower_current_ma,
	input  logic [15:0] front_lux,
	input  logic [15:0] rear_lux,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        has_byte,
	output logic [7:0]  tx_byte,
	output logic        last,
	output logic        mode_changed,
	output logic        brightness_changed,
	output logic [15:0] mode_value,
	output logic [7:0]  brightness_value
);
	logic [7:0]  slave_q, bcast_q;
	logic [15:0] board_q, date_q, time_q, ver_q, mask_q;
	logic        full, push, nempty, pop;
	job_t        wjob, rjob;

	// Configuration registers: the user must write them only while idle; the block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_q <= 8'd1; bcast_q <= '0; board_q <= '0; date_q <= '0;
			time_q <= '0; ver_q <= '0; mask_q <= 16'd31;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SLAVE: slave_q <= cfg_data[7:0];
				REG_BCAST: bcast_q <= cfg_data[7:0];
				REG_BOARD: board_q <= cfg_data;
				REG_DATE:  date_q <= cfg_data;
				REG_TIME:  time_q <= cfg_data;
				REG_VER:   ver_q <= cfg_data;
				REG_MASK:  mask_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Front: accept byte transactions, classify each frame end.
	mrs_front #(.RX_FRAME_MAX(RX_FRAME_MAX)) u_front (
		.clk, .arst_n, .in_valid, .in_ready, .cmd, .rx_byte,
		.upper_current_ma, .lower_current_ma, .front_lux, .rear_lux,
		.slave_address(slave_q), .broadcast_address(bcast_q),
		.mode_valid_mask(mask_q), .q_full(full), .push, .job(wjob)
	);

	// Queue: lets the front keep receiving while a reply drains.
	mrs_fifo u_fifo (
		.clk, .arst_n, .push, .wdata(wjob), .full, .pop, .nempty, .rdata(rjob)
	);

	// Back: execute and stream the reply bytes.
	mrs_back u_back (
		.clk, .arst_n, .job_valid(nempty), .job(rjob), .job_pop(pop),
		.slave_address(slave_q), .board_number(board_q), .build_date_word(date_q),
		.build_time_word(time_q), .version_word(ver_q),
		.out_valid, .out_ready, .has_byte, .tx_byte, .last,
		.mode_changed, .brightness_changed, .mode_value, .brightness_value
	);

	`MRS_ASSERT_IMPL(a_no_push_full, full, !push)
	`MRS_ASSERT_IMPL(a_flag_on_last, out_valid && (mode_changed || brightness_changed), last)
	`MRS_ASSERT_IMPL(a_status_is_last, out_valid && !has_byte, last)
	`MRS_ASSERT_NEXT(a_pop_gives_out, pop, out_valid)
endmodule

// File: verif/modbus_rtu_slave_engine_core_tb.sv
// Testbench for the Modbus RTU slave engine: framed requests, noise and config sweeps.
// Depends on mrs_pkg and modbus_rtu_slave_engine_core; self-checking, no files read.
`timescale 1ns / 1ps
module modbus_rtu_slave_engine_core_tb;
	import mrs_pkg::*;

	localparam int FRAME_MAX    = 256;
	localparam int DRAIN_CYCLES = 60;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int ITEM_TARGET  = 380;
	localparam int LOOP_TARGET  = ITEM_TARGET - FRAME_MAX - 12;
	localparam int PHASE_ITEMS  = 30;
	localparam bit CMD_BYTE     = 1'b0;
	localparam bit CMD_END      = 1'b1;

	typedef struct {
		bit          cmd;
		logic [7:0]  rx_byte;
		logic [15:0] up_ma;
		logic [15:0] lo_ma;
		logic [15:0] lux_f;
		logic [15:0] lux_b;
	} rx_item_t;

	typedef struct {
		bit          has_byte;
		logic [7:0]  tx_byte;
		bit          last;
		bit          mode_changed;
		bit          bright_changed;
		logic [15:0] mode_value;
		logic [7:0]  bright_value;
	} reply_t;

	// Bitwise Modbus CRC-16, reflected polynomial 0xA001.
	function automatic logic [15:0] crc16_step(logic [15:0] crc, logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		repeat (8) c = (c >> 1) ^ (c[0] ? 16'hA001 : 16'h0000);
		return c;
	endfunction

	// Predicts reply bytes of the slave and holds them until the block produces them.
	class reply_scoreboard;
		reply_t      pending_q[$];
		int          errs;
		logic [7:0]  own_addr, bcast_addr;
		logic [15:0] board, build_date, build_time, version, mode_mask;
		logic [7:0]  head[6];
		int          rx_len;
		logic [15:0] run_crc, tail;
		logic [15:0] mode_reg;
		logic [7:0]  bright_reg;

		function new();
			own_addr = 8'd1; bcast_addr = 8'd0;
			board = 0; build_date = 0; build_time = 0; version = 0; mode_mask = 16'd31;
			foreach (head[i]) head[i] = 8'h00;
			rx_len = 0; run_crc = 16'hFFFF; tail = 0; mode_reg = 0; bright_reg = 0;
			errs = 0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [15:0] val);
			case (idx)
				REG_SLAVE: own_addr = val[7:0];
				REG_BCAST: bcast_addr = val[7:0];
				REG_BOARD: board = val;
				REG_DATE:  build_date = val;
				REG_TIME:  build_time = val;
				REG_VER:   version = val;
				REG_MASK:  mode_mask = val;
				default: ;
			endcase
		endfunction

		function void note_item(rx_item_t it);
			logic [7:0]  rsp[32];
			logic [15:0] regs[11];
			logic [15:0] c;
			logic [7:0]  code;
			int          n, a, v;
			bit          mchg, bchg;
			reply_t      r;
			n = 0; mchg = 0; bchg = 0;
			if (it.cmd == CMD_BYTE) begin
				if (rx_len < 6) head[rx_len] = it.rx_byte;
				if (rx_len >= 2) run_crc = crc16_step(run_crc, tail[15:8]);
				tail = {tail[7:0], it.rx_byte};
				if (rx_len <= FRAME_MAX) rx_len++;
				return;
			end
			code = head[1];
			if (rx_len >= 4 && rx_len <= FRAME_MAX &&
					(head[0] == own_addr || head[0] == bcast_addr) &&
					run_crc == {tail[7:0], tail[15:8]}) begin
				a = int'({head[2], head[3]});
				v = int'({head[4], head[5]});
				rsp[0] = own_addr; rsp[1] = code | EXC_FLAG; n = 3;
				if (rx_len != 8 || !(code == FC_READ_HOLD || code == FC_READ_INPUT ||
						code == FC_WRITE_ONE)) begin
					rsp[2] = EXC_FUNC;
				end else if (code == FC_WRITE_ONE) begin
					if (a == 0 && v < 16 && mode_mask[v]) begin
						mode_reg = 16'(v); mchg = 1;
					end else if (a == 1 && v <= 255) begin
						bright_reg = 8'(v); bchg = 1;
					end
					if (mchg || bchg) begin
						for (int i = 0; i < 6; i++) rsp[i] = head[i];
						n = 6;
					end else begin
						rsp[2] = (a > 1) ? EXC_ADDR : EXC_VALUE;
					end
				end else begin
					int lim;
					if (code == FC_READ_HOLD) begin
						lim = 2;
						regs[0] = mode_reg; regs[1] = {8'h00, bright_reg};
					end else begin
						lim = INPUT_REG_COUNT;
						regs[0] = board; regs[1] = build_date; regs[2] = build_time;
						regs[3] = version; regs[4] = mode_reg; regs[5] = it.up_ma;
						regs[6] = 16'h0000; regs[7] = it.lo_ma; regs[8] = 16'h0000;
						regs[9] = it.lux_f; regs[10] = it.lux_b;
					end
					if (a >= lim) rsp[2] = EXC_ADDR;
					else if (v == 0 || v + a > lim) rsp[2] = EXC_VALUE;
					else begin
						rsp[1] = code; rsp[2] = 8'(v * 2);
						for (int i = 0; i < v; i++) begin
							rsp[n++] = regs[a + i][15:8];
							rsp[n++] = regs[a + i][7:0];
						end
					end
				end
				// Broadcast frames execute silently.
				if (head[0] == own_addr) begin
					c = 16'hFFFF;
					for (int i = 0; i < n; i++) c = crc16_step(c, rsp[i]);
					rsp[n++] = c[7:0];
					rsp[n++] = c[15:8];
				end else n = 0;
			end
			rx_len = 0; run_crc = 16'hFFFF; tail = 0;
			if (n == 0) begin
				r = '{0, 8'h00, 1, mchg, bchg, mode_reg, bright_reg};
				pending_q.push_back(r);
			end
			for (int k = 0; k < n; k++) begin
				r = '{1, rsp[k], k == n - 1, (k == n - 1) && mchg, (k == n - 1) && bchg,
					mode_reg, bright_reg};
				pending_q.push_back(r);
			end
		endfunction

		function void check_reply(reply_t got);
			reply_t e;
			if (pending_q.size() == 0) begin
				$error("unexpected reply transaction, tx_byte %h", got.tx_byte);
				errs++;
				return;
			end
			e = pending_q.pop_front();
			if (got.has_byte != e.has_byte) begin
				$error("has_byte: expected %0d got %0d", e.has_byte, got.has_byte); errs++;
			end
			if (got.tx_byte != e.tx_byte) begin
				$error("tx_byte: expected %h got %h", e.tx_byte, got.tx_byte); errs++;
			end
			if (got.last != e.last) begin
				$error("last: expected %0d got %0d", e.last, got.last); errs++;
			end
			if (got.mode_changed != e.mode_changed) begin
				$error("mode_changed: expected %0d got %0d", e.mode_changed,
					got.mode_changed); errs++;
			end
			if (got.bright_changed != e.bright_changed) begin
				$error("brightness_changed: expected %0d got %0d", e.bright_changed,
					got.bright_changed); errs++;
			end
			if (got.mode_value != e.mode_value) begin
				$error("mode_value: expected %h got %h", e.mode_value, got.mode_value); errs++;
			end
			if (got.bright_value != e.bright_value) begin
				$error("brightness_value: expected %h got %h", e.bright_value,
					got.bright_value); errs++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = REG_SLAVE;
	logic [15:0] cfg_data = 16'h0000;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        cmd = 1'b0;
	logic [7:0]  rx_byte = 8'h00;
	logic [15:0] upper_current_ma = 16'h0000;
	logic [15:0] lower_current_ma = 16'h0000;
	logic [15:0] front_lux = 16'h0000;
	logic [15:0] rear_lux = 16'h0000;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        has_byte, last, mode_changed, brightness_changed;
	logic [7:0]  tx_byte, brightness_value;
	logic [15:0] mode_value;

	reply_scoreboard sb = new();
	int cycle_count = 0;
	int items_sent = 0;
	int burst_left = 0;
	int stall_mode = 0;

	modbus_rtu_slave_engine_core dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.cmd(cmd), .rx_byte(rx_byte),
		.upper_current_ma(upper_current_ma), .lower_current_ma(lower_current_ma),
		.front_lux(front_lux), .rear_lux(rear_lux),
		.out_valid(out_valid), .out_ready(out_ready),
		.has_byte(has_byte), .tx_byte(tx_byte), .last(last),
		.mode_changed(mode_changed), .brightness_changed(brightness_changed),
		.mode_value(mode_value), .brightness_value(brightness_value)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Guard against a hung handshake.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Receiver: switch stall pattern at random between free running, 50/50, or mostly stalled.
	always @(posedge clk) begin
		if (cycle_count % 64 == 0) stall_mode = $urandom_range(0, 2);
		case (stall_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= 1'($urandom_range(0, 1));
			default: out_ready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	// Monitor: sample the reply transaction on the edge that accepts it.
	always @(posedge clk) begin
		reply_t got;
		if (arst_n && out_valid && out_ready) begin
			got = '{has_byte, tx_byte, last, mode_changed, brightness_changed,
				mode_value, brightness_value};
			sb.check_reply(got);
		end
	end

	// Send one item; the sender works in bursts with random gaps in between.
	// Ready is sampled between edges, so the accepting edge is known before it comes.
	task automatic send_item(rx_item_t it);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
		end
		in_valid <= 1'b1;
		cmd <= it.cmd;
		rx_byte <= it.rx_byte;
		upper_current_ma <= it.up_ma;
		lower_current_ma <= it.lo_ma;
		front_lux <= it.lux_f;
		rear_lux <= it.lux_b;
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
		sb.note_item(it);
		items_sent++;
		burst_left--;
	endtask

	function automatic rx_item_t rand_item(bit c);
		rx_item_t it;
		it.cmd = c;
		it.rx_byte = 8'($urandom_range(0, 255));
		it.up_ma = 16'($urandom_range(0, 65535));
		it.lo_ma = 16'($urandom_range(0, 65535));
		it.lux_f = 16'($urandom_range(0, 65535));
		it.lux_b = 16'($urandom_range(0, 65535));
		return it;
	endfunction

	// Send the frame bytes then the line-gap marker.
	task automatic send_frame(logic [7:0] bytes[$], logic [15:0] live);
		rx_item_t it;
		foreach (bytes[i]) begin
			it = rand_item(CMD_BYTE);
			it.rx_byte = bytes[i];
			send_item(it);
		end
		it = rand_item(CMD_END);
		if (live != 16'h1234) begin
			it.up_ma = live; it.lo_ma = live; it.lux_f = live; it.lux_b = live;
		end
		send_item(it);
	endtask

	function automatic void append_crc(ref logic [7:0] bytes[$]);
		logic [15:0] c;
		c = 16'hFFFF;
		foreach (bytes[i]) c = crc16_step(c, bytes[i]);
		bytes.push_back(c[7:0]);
		bytes.push_back(c[15:8]);
	endfunction

	// Drain: drop valid, let every expected reply arrive, then allow the back end to settle.
	task automatic wait_idle();
		in_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (sb.pending_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		sb.set_reg(idx, val);
		@(posedge clk);
	endtask

	// Write all registers for a phase; picks cover the extremes and the shared address.
	task automatic config_phase(int ph);
		logic [7:0] sa, ba;
		sa = (ph % 3 == 0) ? 8'd1 : (ph % 3 == 1) ? 8'd247 : 8'($urandom_range(1, 247));
		case (ph % 4)
			0: ba = 8'd0;
			1: ba = 8'd255;
			2: ba = sa;
			default: ba = 8'($urandom_range(0, 255));
		endcase
		write_reg(REG_SLAVE, {8'h00, sa});
		write_reg(REG_BCAST, {8'h00, ba});
		write_reg(REG_BOARD, (ph % 2) ? 16'hFFFF : 16'($urandom_range(0, 65535)));
		write_reg(REG_DATE, (ph % 2) ? 16'h0000 : 16'($urandom_range(0, 65535)));
		write_reg(REG_TIME, 16'($urandom_range(0, 65535)));
		write_reg(REG_VER, (ph % 3 == 2) ? 16'hFFFF : 16'($urandom_range(0, 65535)));
		case (ph % 4)
			0: write_reg(REG_MASK, 16'h0000);
			1: write_reg(REG_MASK, 16'hFFFF);
			default: write_reg(REG_MASK, 16'($urandom_range(0, 65535)));
		endcase
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Build one random frame: mostly well-formed requests, the rest broken or noise.
	task automatic random_frame();
		logic [7:0] f[$];
		logic [7:0] code;
		int sel, a, v, n;
		sel = $urandom_range(0, 99);
		f.delete();
		if (sel < 88) begin
			case ($urandom_range(0, 9))
				0: f.push_back(sb.bcast_addr);
				1: f.push_back(8'($urandom_range(0, 255)));
				default: f.push_back(sb.own_addr);
			endcase
			case ($urandom_range(0, 9))
				0, 1, 2: code = FC_READ_HOLD;
				3, 4, 5: code = FC_READ_INPUT;
				6, 7, 8: code = FC_WRITE_ONE;
				default: code = 8'($urandom_range(0, 255));
			endcase
			f.push_back(code);
			case ($urandom_range(0, 5))
				0: begin a = $urandom_range(0, 65535); v = $urandom_range(0, 65535); end
				1: begin a = $urandom_range(0, 2); v = $urandom_range(0, 300); end
				default: begin
					a = $urandom_range(0, (code == FC_READ_INPUT) ? 12 : 2);
					v = (code == FC_WRITE_ONE && a == 0) ? $urandom_range(0, 17)
						: $urandom_range(0, 12);
				end
			endcase
			f.push_back(a[15:8]); f.push_back(a[7:0]);
			f.push_back(v[15:8]); f.push_back(v[7:0]);
			// Wrong length with good CRC.
			if (sel >= 78) begin
				n = $urandom_range(0, 1) ? $urandom_range(0, 3) : 0;
				if (n == 0) repeat ($urandom_range(1, 4)) void'(f.pop_back());
				else repeat (n) f.push_back(8'($urandom_range(0, 255)));
			end
			append_crc(f);
			// Corrupt the CRC or a payload bit.
			if (sel >= 68 && sel < 78) begin
				n = $urandom_range(0, f.size() - 1);
				f[n] = f[n] ^ (8'h01 << $urandom_range(0, 7));
			end
		end else if (sel < 94) begin
			repeat ($urandom_range(0, 3)) f.push_back(8'($urandom_range(0, 255)));
		end else begin
			repeat ($urandom_range(4, 12)) f.push_back(8'($urandom_range(0, 255)));
		end
		send_frame(f, 16'h1234);
	endtask

	initial begin
		logic [7:0] f[$];
		int ph;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: full input register read at extreme live values.
		f = '{8'd1, FC_READ_INPUT, 8'h00, 8'h00, 8'h00, 8'd11};
		append_crc(f);
		send_frame(f, 16'hFFFF);
		// Short frame, not answered.
		f = '{8'd1};
		send_frame(f, 16'h0000);
		// Broadcast write of mode: executes, status only.
		f = '{8'd0, FC_WRITE_ONE, 8'h00, 8'h00, 8'h00, 8'h03};
		append_crc(f);
		send_frame(f, 16'h0000);
		wait_idle();

		ph = 0;
		config_phase(ph);
		while (items_sent < LOOP_TARGET) begin
			random_frame();
			if (items_sent / PHASE_ITEMS != ph) begin
				wait_idle();
				ph++;
				config_phase(ph);
			end
		end

		// Overlong frame: the length saturates past the maximum, nothing is executed.
		f.delete();
		f.push_back(sb.own_addr);
		repeat (FRAME_MAX - 3) f.push_back(8'($urandom_range(0, 255)));
		append_crc(f);
		f.push_back(8'($urandom_range(0, 255)));
		send_frame(f, 16'h1234);
		random_frame();

		wait_idle();
		if (sb.errs == 0 && sb.pending_q.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end
endmodule
